>>> rtl/sclx_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sclx_pkg;

    localparam int MAX_RESULTS = 4;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
    localparam int IDX_W       = $clog2(MAX_RESULTS);

    localparam int TOKEN_LIMIT       = 64;
    localparam int WORD_BUFFER_BYTES = 64;
    localparam int ARGV_SLOTS        = 16;
    localparam int MAX_COMMANDS      = 8;
    localparam int POOL_BYTES        = 1024;

    typedef enum logic [2:0] {
        EV_BYTE   = 3'd0,
        EV_WEND   = 3'd1,
        EV_PIPE   = 3'd2,
        EV_IN     = 3'd3,
        EV_OUT    = 3'd4,
        EV_APPEND = 3'd5,
        EV_ERRDIR = 3'd6,
        EV_DONE   = 3'd7
    } t_ev_kind;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_TOKENS   = 3'd1;
    localparam logic [2:0] ST_COMMANDS = 3'd2;
    localparam logic [2:0] ST_ARGS     = 3'd3;
    localparam logic [2:0] ST_TARGET   = 3'd4;
    localparam logic [2:0] ST_POOL     = 3'd5;

    localparam logic [1:0] ROLE_ARG = 2'd0;
    localparam logic [1:0] ROLE_IN  = 2'd1;
    localparam logic [1:0] ROLE_OUT = 2'd2;

    typedef struct packed {
        t_ev_kind    kind;
        logic [7:0]  data;
        logic [2:0]  cmd;
        logic [3:0]  arg;
        logic [1:0]  role;
        logic        wild;
        logic        qs;
        logic [3:0]  cc;
        logic [2:0]  st;
    } t_event;

    typedef struct packed {
        t_event [MAX_RESULTS-1:0] ev;
        logic   [CNT_W-1:0]       cnt;
    } t_evlist;

endpackage

`default_nettype wire

>>> rtl/shell_command_line_lexer_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Command line lexer: bytes of a line enter on the slave stream, tlast marks the end of
// the line (its data byte is ignored), and token events leave on the master stream with the
// event kind in tuser. Each request is decoded in the cycle it is accepted and yields zero
// to four events, held in a four-entry result register and sent one per cycle while the
// master side is ready; tlast on the master side marks the last event of a request.
// A request that yields events holds off the next one until the result register has
// drained; the next request is taken in the same cycle that the last event of the previous
// one leaves. Errors are latched and reported in the status of the line done event, after
// which all line state returns to its reset value.
module shell_command_line_lexer_unit #(
    parameter int TOKEN_LIMIT       = sclx_pkg::TOKEN_LIMIT,
    parameter int WORD_BUFFER_BYTES = sclx_pkg::WORD_BUFFER_BYTES,
    parameter int ARGV_SLOTS        = sclx_pkg::ARGV_SLOTS,
    parameter int MAX_COMMANDS      = sclx_pkg::MAX_COMMANDS,
    parameter int POOL_BYTES        = sclx_pkg::POOL_BYTES
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [7:0]  s_axis_tdata,   // char_byte[7:0]
    input  wire         s_axis_tlast,   // line_end
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [31:0] m_axis_tdata,   // data_byte[7:0], command_index[10:8],
                                        // argument_index[14:11], word_role[16:15],
                                        // has_wildcard[17], quote_seen[18],
                                        // command_count[22:19], status[25:23], zero[31:26]
    output logic [2:0]  m_axis_tuser,   // event_kind[2:0]
    output logic        m_axis_tlast    // last_of_run
);

    localparam int MAX_RESULTS = sclx_pkg::MAX_RESULTS;
    localparam int CNT_W       = sclx_pkg::CNT_W;
    localparam int IDX_W       = sclx_pkg::IDX_W;

    sclx_pkg::t_evlist                  w_events;
    sclx_pkg::t_event [MAX_RESULTS-1:0] r_ev;
    logic [CNT_W-1:0]                   r_cnt;
    logic [CNT_W-1:0]                   n_cnt;
    logic [IDX_W-1:0]                   r_idx;
    logic [IDX_W-1:0]                   n_idx;
    logic                               r_le;
    sclx_pkg::t_event                   w_cur;
    logic                               w_last;
    logic                               w_in_fire;
    logic                               w_out_fire;

    sclx_core #(
        .TOKEN_LIMIT       (TOKEN_LIMIT),
        .WORD_BUFFER_BYTES (WORD_BUFFER_BYTES),
        .ARGV_SLOTS        (ARGV_SLOTS),
        .MAX_COMMANDS      (MAX_COMMANDS),
        .POOL_BYTES        (POOL_BYTES)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (w_in_fire),
        .i_char     (s_axis_tdata),
        .i_line_end (s_axis_tlast),
        .o_events   (w_events)
    );

    assign w_cur         = r_ev[r_idx];
    assign w_last        = (CNT_W'(r_idx) == r_cnt - CNT_W'(1));
    assign m_axis_tvalid = (r_cnt != '0);
    assign w_out_fire    = m_axis_tvalid && m_axis_tready;
    assign s_axis_tready = (r_cnt == '0) || (w_out_fire && w_last);
    assign w_in_fire     = s_axis_tvalid && s_axis_tready;

    assign m_axis_tdata  = {6'd0, w_cur.st, w_cur.cc, w_cur.qs, w_cur.wild,
                            w_cur.role, w_cur.arg, w_cur.cmd, w_cur.data};
    assign m_axis_tuser  = w_cur.kind;
    assign m_axis_tlast  = w_last;

    always_comb begin
        n_cnt = r_cnt;
        n_idx = r_idx;
        if (w_in_fire) begin
            n_cnt = w_events.cnt;
            n_idx = '0;
        end else if (w_out_fire) begin
            if (w_last) begin
                n_cnt = '0;
                n_idx = '0;
            end else begin
                n_idx = r_idx + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_idx <= '0;
        end else begin
            r_cnt <= n_cnt;
            r_idx <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_ev <= w_events.ev;
            r_le <= s_axis_tlast;
        end
    end

`ifndef SYNTHESIS
    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (CNT_W'(r_idx) < r_cnt))
        else $error("result index beyond result count");

    a_done_ends_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ((m_axis_tuser == sclx_pkg::EV_DONE) == (r_le && w_last)))
        else $error("line done not the last event of a line end request");

    a_status_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser != sclx_pkg::EV_DONE)
            |-> (m_axis_tdata[25:23] == sclx_pkg::ST_OK))
        else $error("status reported outside line done");

    a_events_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_fire && w_events.cnt != '0) |=> m_axis_tvalid)
        else $error("events of an accepted request not presented");
`endif

endmodule

`default_nettype wire

>>> rtl/sclx_core.sv
`timescale 1ns / 1ps
`default_nettype none

module sclx_core #(
    parameter int TOKEN_LIMIT       = sclx_pkg::TOKEN_LIMIT,
    parameter int WORD_BUFFER_BYTES = sclx_pkg::WORD_BUFFER_BYTES,
    parameter int ARGV_SLOTS        = sclx_pkg::ARGV_SLOTS,
    parameter int MAX_COMMANDS      = sclx_pkg::MAX_COMMANDS,
    parameter int POOL_BYTES        = sclx_pkg::POOL_BYTES
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_accept,
    input  wire  [7:0]          i_char,
    input  wire                 i_line_end,
    output sclx_pkg::t_evlist   o_events
);

    localparam int CNT_W               = sclx_pkg::CNT_W;
    localparam int IDX_W               = sclx_pkg::IDX_W;

    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_PIPE   = 8'h7C;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_TWO    = 8'h32;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_QMARK  = 8'h3F;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;

    typedef enum logic [2:0] {
        MODE_BETWEEN = 3'b001,
        MODE_WORD    = 3'b010,
        MODE_QUOTED  = 3'b100
    } t_lex_mode;

    typedef enum logic [1:0] {
        LA_NONE = 2'd0,
        LA_GT   = 2'd1,
        LA_TWO  = 2'd2
    } t_lookahead;

    typedef struct packed {
        t_lex_mode   lex_mode;
        logic        quote_kind;
        t_lookahead  pend;
        logic [6:0]  word_len;
        logic        wild;
        logic [6:0]  tok_cnt;
        logic [2:0]  cmd_idx;
        logic [3:0]  arg_cnt;
        logic [1:0]  target;
        logic [10:0] pool;
        logic        qflag;
        logic [2:0]  err;
    } t_state;

    t_state            r_st;
    t_state            n_st;
    sclx_pkg::t_evlist w_events;

    function automatic t_state clear_state();
        t_state s;
        s          = '0;
        s.lex_mode = MODE_BETWEEN;
        s.pend     = LA_NONE;
        s.err      = sclx_pkg::ST_OK;
        return s;
    endfunction

    function automatic void put(input t_state s, inout sclx_pkg::t_evlist e,
                                input sclx_pkg::t_ev_kind k, input logic [7:0] d,
                                input logic [1:0] role, input logic wild,
                                input logic qs, input logic [3:0] cc,
                                input logic [2:0] st);
        if (e.cnt < CNT_W'(sclx_pkg::MAX_RESULTS)) begin
            e.ev[e.cnt[IDX_W-1:0]].kind = k;
            e.ev[e.cnt[IDX_W-1:0]].data = d;
            e.ev[e.cnt[IDX_W-1:0]].cmd  = s.cmd_idx;
            e.ev[e.cnt[IDX_W-1:0]].arg  = s.arg_cnt;
            e.ev[e.cnt[IDX_W-1:0]].role = role;
            e.ev[e.cnt[IDX_W-1:0]].wild = wild;
            e.ev[e.cnt[IDX_W-1:0]].qs   = qs;
            e.ev[e.cnt[IDX_W-1:0]].cc   = cc;
            e.ev[e.cnt[IDX_W-1:0]].st   = st;
            e.cnt = e.cnt + CNT_W'(1);
        end
    endfunction

    function automatic void end_word(inout t_state s, inout sclx_pkg::t_evlist e);
        logic [1:0] role;
        role = s.target;
        if (s.err != sclx_pkg::ST_OK) return;
        if (s.word_len == 7'd0) begin
            s.wild = 1'b0;
            return;
        end
        if (s.tok_cnt >= 7'(TOKEN_LIMIT)) begin
            s.err = sclx_pkg::ST_TOKENS;
            return;
        end
        if ({1'b0, s.pool} + 12'(s.word_len) + 12'd1 > 12'(POOL_BYTES)) begin
            s.err = sclx_pkg::ST_POOL;
            return;
        end
        if (role == sclx_pkg::ROLE_ARG && s.arg_cnt >= 4'(ARGV_SLOTS - 1)) begin
            s.err = sclx_pkg::ST_ARGS;
            return;
        end
        put(s, e, sclx_pkg::EV_WEND, 8'd0, role, s.wild, 1'b0, 4'd0, sclx_pkg::ST_OK);
        s.pool    = s.pool + 11'(s.word_len) + 11'd1;
        s.tok_cnt = s.tok_cnt + 7'd1;
        if (role != sclx_pkg::ROLE_ARG) begin
            s.target = sclx_pkg::ROLE_ARG;
        end else begin
            s.arg_cnt = s.arg_cnt + 4'd1;
        end
        s.word_len = 7'd0;
        s.wild     = 1'b0;
    endfunction

    function automatic void append(inout t_state s, inout sclx_pkg::t_evlist e,
                                   input logic [7:0] c);
        if (s.err != sclx_pkg::ST_OK) return;
        if (s.lex_mode == MODE_BETWEEN) s.lex_mode = MODE_WORD;
        put(s, e, sclx_pkg::EV_BYTE, c, s.target, 1'b0, 1'b0, 4'd0, sclx_pkg::ST_OK);
        s.word_len = s.word_len + 7'd1;
        if (c == CH_STAR || c == CH_QMARK) s.wild = 1'b1;
        // long word splits here, an open quote stays open
        if (s.word_len >= 7'(WORD_BUFFER_BYTES - 1)) begin
            end_word(s, e);
            if (s.lex_mode == MODE_WORD) s.lex_mode = MODE_BETWEEN;
        end
    endfunction

    function automatic void close_word(inout t_state s, inout sclx_pkg::t_evlist e);
        if (s.lex_mode == MODE_WORD) end_word(s, e);
        s.lex_mode = MODE_BETWEEN;
    endfunction

    function automatic void op(inout t_state s, inout sclx_pkg::t_evlist e,
                               input sclx_pkg::t_ev_kind k, input logic [1:0] tgt);
        if (s.err != sclx_pkg::ST_OK) return;
        if (s.tok_cnt >= 7'(TOKEN_LIMIT)) begin
            s.err = sclx_pkg::ST_TOKENS;
            return;
        end
        if (s.target != sclx_pkg::ROLE_ARG) begin
            s.err = sclx_pkg::ST_TARGET;
            return;
        end
        if (k == sclx_pkg::EV_PIPE) begin
            if ({1'b0, s.cmd_idx} + 4'd1 >= 4'(MAX_COMMANDS)) begin
                s.err = sclx_pkg::ST_COMMANDS;
                return;
            end
            put(s, e, sclx_pkg::EV_PIPE, 8'd0, sclx_pkg::ROLE_ARG, 1'b0, 1'b0, 4'd0,
                sclx_pkg::ST_OK);
            s.cmd_idx = s.cmd_idx + 3'd1;
            s.arg_cnt = 4'd0;
        end else begin
            put(s, e, k, 8'd0, sclx_pkg::ROLE_ARG, 1'b0, 1'b0, 4'd0, sclx_pkg::ST_OK);
            s.target = tgt;
        end
        s.tok_cnt = s.tok_cnt + 7'd1;
    endfunction

    function automatic void feed(inout t_state s, inout sclx_pkg::t_evlist e,
                                 input logic [7:0] c);
        logic [7:0] q;
        q = s.quote_kind ? CH_DQUOTE : CH_SQUOTE;
        if (s.err != sclx_pkg::ST_OK) return;
        if (s.lex_mode == MODE_QUOTED) begin
            if (c == q) begin
                s.lex_mode = MODE_WORD;
            end else begin
                append(s, e, c);
            end
            return;
        end
        if (c == CH_SPACE || c == CH_TAB) begin
            close_word(s, e);
        end else if (c == CH_PIPE) begin
            close_word(s, e);
            op(s, e, sclx_pkg::EV_PIPE, sclx_pkg::ROLE_ARG);
        end else if (c == CH_LT) begin
            close_word(s, e);
            op(s, e, sclx_pkg::EV_IN, sclx_pkg::ROLE_IN);
        end else if (c == CH_GT) begin
            close_word(s, e);
            s.pend = LA_GT;
        end else if (c == CH_TWO) begin
            s.pend = LA_TWO;
        end else if (c == CH_SQUOTE || c == CH_DQUOTE) begin
            s.qflag      = 1'b1;
            s.quote_kind = (c == CH_DQUOTE);
            s.lex_mode   = MODE_QUOTED;
        end else begin
            append(s, e, c);
        end
    endfunction

    function automatic void take_byte(inout t_state s, inout sclx_pkg::t_evlist e,
                                      input logic [7:0] c);
        t_lookahead la;
        la     = s.pend;
        s.pend = LA_NONE;
        if (la == LA_GT) begin
            if (c == CH_GT) begin
                op(s, e, sclx_pkg::EV_APPEND, sclx_pkg::ROLE_OUT);
                return;
            end
            op(s, e, sclx_pkg::EV_OUT, sclx_pkg::ROLE_OUT);
        end else if (la == LA_TWO) begin
            if (c == CH_GT) begin
                close_word(s, e);
                op(s, e, sclx_pkg::EV_ERRDIR, sclx_pkg::ROLE_OUT);
                return;
            end
            append(s, e, CH_TWO);
        end
        feed(s, e, c);
    endfunction

    function automatic void finish_line(inout t_state s, inout sclx_pkg::t_evlist e);
        logic [3:0] cc;
        cc = 4'd0;
        if (s.err == sclx_pkg::ST_OK) begin
            if (s.pend == LA_GT) begin
                op(s, e, sclx_pkg::EV_OUT, sclx_pkg::ROLE_OUT);
            end else if (s.pend == LA_TWO) begin
                append(s, e, CH_TWO);
            end
            s.pend = LA_NONE;
            if (s.lex_mode != MODE_BETWEEN) end_word(s, e);
            s.lex_mode = MODE_BETWEEN;
            if (s.err == sclx_pkg::ST_OK && s.target != sclx_pkg::ROLE_ARG) begin
                s.err = sclx_pkg::ST_TARGET;
            end
        end
        if (s.tok_cnt != 7'd0) cc = {1'b0, s.cmd_idx} + 4'd1;
        put(s, e, sclx_pkg::EV_DONE, 8'd0, sclx_pkg::ROLE_ARG, 1'b0, s.qflag, cc, s.err);
        s = clear_state();
    endfunction

    always_comb begin
        n_st     = r_st;
        w_events = '0;
        if (i_line_end) begin
            finish_line(n_st, w_events);
        end else if (n_st.err == sclx_pkg::ST_OK) begin
            take_byte(n_st, w_events, i_char);
        end
    end

    assign o_events = w_events;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= clear_state();
        end else if (i_accept) begin
            r_st <= n_st;
        end
    end

endmodule

`default_nettype wire

>>> bench/lexer_event_checker.sv
`timescale 1ns / 1ps

module lexer_event_checker (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_axis_tvalid,
    input  wire         i_s_axis_tready,
    input  wire  [7:0]  i_s_axis_tdata,
    input  wire         i_s_axis_tlast,
    input  wire         i_m_axis_tvalid,
    input  wire         i_m_axis_tready,
    input  wire  [31:0] i_m_axis_tdata,
    input  wire  [2:0]  i_m_axis_tuser,
    input  wire         i_m_axis_tlast,
    output int          o_fail_count,
    output int          o_pending
);

    localparam int TOKEN_LIMIT  = sclx_pkg::TOKEN_LIMIT;
    localparam int WORD_BYTES   = sclx_pkg::WORD_BUFFER_BYTES;
    localparam int ARGV_SLOTS   = sclx_pkg::ARGV_SLOTS;
    localparam int MAX_COMMANDS = sclx_pkg::MAX_COMMANDS;
    localparam int POOL_BYTES   = sclx_pkg::POOL_BYTES;

    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_PIPE   = 8'h7C;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_TWO    = 8'h32;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_QUEST  = 8'h3F;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;

    typedef enum logic [1:0] {
        MODE_BETWEEN,
        MODE_WORD,
        MODE_QUOTED
    } t_lex_mode;

    typedef enum logic [1:0] {
        LA_NONE,
        LA_GT,
        LA_TWO
    } t_lookahead;

    typedef struct packed {
        sclx_pkg::t_event ev;
        logic             last;
    } t_expected_event;

    t_lex_mode        mode;
    logic             in_dquote;
    t_lookahead       lookahead;
    int unsigned      word_len;
    logic             word_wild;
    int unsigned      tokens;
    logic [2:0]       cmd_idx;
    logic [3:0]       arg_idx;
    logic [1:0]       target;
    int unsigned      pool_used;
    logic             quote_flag;
    logic [2:0]       status;

    sclx_pkg::t_event step_events[$];
    t_expected_event  expected_events[$];
    t_expected_event  want;

    function automatic void clear_line();
        mode       = MODE_BETWEEN;
        in_dquote  = 1'b0;
        lookahead  = LA_NONE;
        word_len   = 0;
        word_wild  = 1'b0;
        tokens     = 0;
        cmd_idx    = '0;
        arg_idx    = '0;
        target     = sclx_pkg::ROLE_ARG;
        pool_used  = 0;
        quote_flag = 1'b0;
        status     = sclx_pkg::ST_OK;
    endfunction

    function automatic void emit(input sclx_pkg::t_ev_kind kind, input logic [7:0] data,
                                 input logic [1:0] role, input logic wild,
                                 input logic qs, input logic [3:0] cc,
                                 input logic [2:0] st);
        sclx_pkg::t_event ev;
        if (step_events.size() >= sclx_pkg::MAX_RESULTS) return;
        ev.kind = kind;
        ev.data = data;
        ev.cmd  = cmd_idx;
        ev.arg  = arg_idx;
        ev.role = role;
        ev.wild = wild;
        ev.qs   = qs;
        ev.cc   = cc;
        ev.st   = st;
        step_events.push_back(ev);
    endfunction

    function automatic void end_word();
        logic [1:0] role;
        if (status != sclx_pkg::ST_OK) return;
        if (word_len == 0) begin
            word_wild = 1'b0;
            return;
        end
        if (tokens >= TOKEN_LIMIT) begin
            status = sclx_pkg::ST_TOKENS;
            return;
        end
        if (pool_used + word_len + 1 > POOL_BYTES) begin
            status = sclx_pkg::ST_POOL;
            return;
        end
        role = target;
        if (role == sclx_pkg::ROLE_ARG && arg_idx >= ARGV_SLOTS - 1) begin
            status = sclx_pkg::ST_ARGS;
            return;
        end
        emit(sclx_pkg::EV_WEND, 8'h00, role, word_wild, 1'b0, 4'd0, sclx_pkg::ST_OK);
        pool_used += word_len + 1;
        tokens++;
        if (role != sclx_pkg::ROLE_ARG) target = sclx_pkg::ROLE_ARG;
        else arg_idx++;
        word_len  = 0;
        word_wild = 1'b0;
    endfunction

    function automatic void add_byte(input logic [7:0] c);
        if (status != sclx_pkg::ST_OK) return;
        if (mode == MODE_BETWEEN) mode = MODE_WORD;
        emit(sclx_pkg::EV_BYTE, c, target, 1'b0, 1'b0, 4'd0, sclx_pkg::ST_OK);
        word_len++;
        if (c == CH_STAR || c == CH_QUEST) word_wild = 1'b1;
        if (word_len >= WORD_BYTES - 1) begin
            end_word();
            if (mode == MODE_WORD) mode = MODE_BETWEEN;
        end
    endfunction

    function automatic void close_word();
        if (mode == MODE_WORD) end_word();
        mode = MODE_BETWEEN;
    endfunction

    function automatic void take_operator(input sclx_pkg::t_ev_kind kind,
                                          input logic [1:0] next_target);
        if (status != sclx_pkg::ST_OK) return;
        if (tokens >= TOKEN_LIMIT) begin
            status = sclx_pkg::ST_TOKENS;
            return;
        end
        if (target != sclx_pkg::ROLE_ARG) begin
            status = sclx_pkg::ST_TARGET;
            return;
        end
        if (kind == sclx_pkg::EV_PIPE) begin
            if (cmd_idx + 1 >= MAX_COMMANDS) begin
                status = sclx_pkg::ST_COMMANDS;
                return;
            end
            emit(sclx_pkg::EV_PIPE, 8'h00, sclx_pkg::ROLE_ARG, 1'b0, 1'b0, 4'd0,
                 sclx_pkg::ST_OK);
            cmd_idx++;
            arg_idx = '0;
        end else begin
            emit(kind, 8'h00, sclx_pkg::ROLE_ARG, 1'b0, 1'b0, 4'd0, sclx_pkg::ST_OK);
            target = next_target;
        end
        tokens++;
    endfunction

    function automatic void scan_byte(input logic [7:0] c);
        logic [7:0] closing;
        if (status != sclx_pkg::ST_OK) return;
        if (mode == MODE_QUOTED) begin
            closing = in_dquote ? CH_DQUOTE : CH_SQUOTE;
            if (c == closing) mode = MODE_WORD;
            else add_byte(c);
            return;
        end
        if (c == CH_SPACE || c == CH_TAB) begin
            close_word();
        end else if (c == CH_PIPE) begin
            close_word();
            take_operator(sclx_pkg::EV_PIPE, sclx_pkg::ROLE_ARG);
        end else if (c == CH_LT) begin
            close_word();
            take_operator(sclx_pkg::EV_IN, sclx_pkg::ROLE_IN);
        end else if (c == CH_GT) begin
            close_word();
            lookahead = LA_GT;
        end else if (c == CH_TWO) begin
            lookahead = LA_TWO;
        end else if (c == CH_SQUOTE || c == CH_DQUOTE) begin
            quote_flag = 1'b1;
            in_dquote  = (c == CH_DQUOTE);
            mode       = MODE_QUOTED;
        end else begin
            add_byte(c);
        end
    endfunction

    function automatic void take_char(input logic [7:0] c);
        t_lookahead held;
        held      = lookahead;
        lookahead = LA_NONE;
        if (held == LA_GT) begin
            if (c == CH_GT) begin
                take_operator(sclx_pkg::EV_APPEND, sclx_pkg::ROLE_OUT);
                return;
            end
            take_operator(sclx_pkg::EV_OUT, sclx_pkg::ROLE_OUT);
        end else if (held == LA_TWO) begin
            if (c == CH_GT) begin
                close_word();
                take_operator(sclx_pkg::EV_ERRDIR, sclx_pkg::ROLE_OUT);
                return;
            end
            add_byte(CH_TWO);
        end
        scan_byte(c);
    endfunction

    function automatic void finish_line();
        logic [3:0] cc;
        if (status == sclx_pkg::ST_OK) begin
            if (lookahead == LA_GT) take_operator(sclx_pkg::EV_OUT, sclx_pkg::ROLE_OUT);
            else if (lookahead == LA_TWO) add_byte(CH_TWO);
            lookahead = LA_NONE;
            if (mode != MODE_BETWEEN) end_word();
            mode = MODE_BETWEEN;
            if (status == sclx_pkg::ST_OK && target != sclx_pkg::ROLE_ARG) begin
                status = sclx_pkg::ST_TARGET;
            end
        end
        cc = (tokens != 0) ? ({1'b0, cmd_idx} + 4'd1) : 4'd0;
        emit(sclx_pkg::EV_DONE, 8'h00, sclx_pkg::ROLE_ARG, 1'b0, quote_flag, cc, status);
        clear_line();
    endfunction

    task automatic lex_request(input logic [7:0] c, input logic line_end);
        t_expected_event rec;
        step_events.delete();
        if (line_end) finish_line();
        else if (status == sclx_pkg::ST_OK) take_char(c);
        foreach (step_events[i]) begin
            rec.ev   = step_events[i];
            rec.last = (i == step_events.size() - 1);
            expected_events.push_back(rec);
        end
    endtask

    task automatic compare_field(input string name, input int exp_val, input int act_val);
        if (exp_val != act_val) begin
            $display("%0t ns: %s expected %0h got %0h", $time, name, exp_val, act_val);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_line();
            expected_events.delete();
        end else begin
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                if (expected_events.size() == 0) begin
                    $display("%0t ns: event expected none got kind %0d tdata %h last %0b",
                             $time, i_m_axis_tuser, i_m_axis_tdata, i_m_axis_tlast);
                    o_fail_count++;
                end else begin
                    want = expected_events.pop_front();
                    compare_field("event_kind", want.ev.kind, i_m_axis_tuser);
                    compare_field("data_byte", want.ev.data, i_m_axis_tdata[7:0]);
                    compare_field("command_index", want.ev.cmd, i_m_axis_tdata[10:8]);
                    compare_field("argument_index", want.ev.arg, i_m_axis_tdata[14:11]);
                    compare_field("word_role", want.ev.role, i_m_axis_tdata[16:15]);
                    compare_field("has_wildcard", want.ev.wild, i_m_axis_tdata[17]);
                    compare_field("quote_seen", want.ev.qs, i_m_axis_tdata[18]);
                    compare_field("command_count", want.ev.cc, i_m_axis_tdata[22:19]);
                    compare_field("status", want.ev.st, i_m_axis_tdata[25:23]);
                    compare_field("tdata padding", 0, i_m_axis_tdata[31:26]);
                    compare_field("last_of_run", want.last, i_m_axis_tlast);
                end
            end
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                lex_request(i_s_axis_tdata, i_s_axis_tlast);
            end
        end
        o_pending = expected_events.size();
    end

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int TOTAL_REQUESTS = 380;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b1;
    logic [31:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;
    logic        m_axis_tlast;

    int          fail_count;
    int          pending;
    int          sent = 0;
    logic        steady = 1'b0;
    logic [7:0]  line_q[$];

    shell_command_line_lexer_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    lexer_event_checker checker_i (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_axis_tvalid),
        .i_s_axis_tready (s_axis_tready),
        .i_s_axis_tdata  (s_axis_tdata),
        .i_s_axis_tlast  (s_axis_tlast),
        .i_m_axis_tvalid (m_axis_tvalid),
        .i_m_axis_tready (m_axis_tready),
        .i_m_axis_tdata  (m_axis_tdata),
        .i_m_axis_tuser  (m_axis_tuser),
        .i_m_axis_tlast  (m_axis_tlast),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(negedge i_clk) begin
        m_axis_tready <= steady || ($urandom_range(0, 99) >= 10);
    end

    // called at a falling edge, returns at the falling edge after the request is taken
    task automatic send_request(input logic [7:0] c, input logic line_end);
        while (!steady && $urandom_range(0, 99) < 10) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        s_axis_tlast  <= line_end;
        do @(posedge i_clk); while (!s_axis_tready);
        sent++;
        @(negedge i_clk);
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++) line_q.push_back(s[i]);
    endtask

    task automatic send_line();
        foreach (line_q[i]) send_request(line_q[i], 1'b0);
        send_request(8'($urandom_range(0, 255)), 1'b1);
        line_q.delete();
    endtask

    task automatic drain_results();
        if (pending != 0) begin
            s_axis_tvalid <= 1'b0;
            while (pending != 0) @(negedge i_clk);
        end
    endtask

    task automatic push_pick(input string alphabet);
        line_q.push_back(alphabet[$urandom_range(0, alphabet.len() - 1)]);
    endtask

    task automatic push_word(input int len);
        for (int i = 0; i < len; i++) push_pick("abcxyz09_-./*?2");
    endtask

    task automatic push_quoted();
        string q;
        int    len;
        q   = $urandom_range(0, 1) ? "\"" : "'";
        len = $urandom_range(0, 6);
        push_text(q);
        for (int i = 0; i < len; i++) push_pick("ab |<>2*?\t'\"");
        push_text(q);
    endtask

    task automatic push_gap();
        int n;
        n = $urandom_range(1, 2);
        for (int i = 0; i < n; i++) push_pick(" \t");
    endtask

    task automatic push_redirect();
        case ($urandom_range(0, 3))
            0: push_text("<");
            1: push_text(">");
            2: push_text(">>");
            default: push_text("2>");
        endcase
    endtask

    function automatic int word_length();
        return ($urandom_range(0, 99) < 8) ? $urandom_range(55, 130) : $urandom_range(1, 6);
    endfunction

    task automatic random_line();
        int ntok;
        int n;
        if ($urandom_range(0, 99) < 15) begin
            n = $urandom_range(1, 12);
            for (int i = 0; i < n; i++) begin
                if ($urandom_range(0, 1)) line_q.push_back(8'($urandom_range(0, 255)));
                else push_pick("|<>2'\" \t*?a");
            end
        end else begin
            ntok = $urandom_range(0, 8);
            for (int k = 0; k < ntok; k++) begin
                case ($urandom_range(0, 9)) inside
                    [0:4]: push_word(word_length());
                    5: push_quoted();
                    6: push_text("|");
                    [7:8]: begin
                        push_redirect();
                        if ($urandom_range(0, 1)) push_gap();
                        push_word(word_length());
                    end
                    default: begin
                        push_word($urandom_range(0, 3));
                        push_quoted();
                        push_word($urandom_range(0, 3));
                    end
                endcase
                if ($urandom_range(0, 99) < 80) push_gap();
            end
        end
        send_line();
    endtask

    task automatic pipeline_line(input int pipes);
        for (int i = 0; i < pipes; i++) begin
            push_word($urandom_range(1, 3));
            push_text("|");
        end
        push_word($urandom_range(1, 3));
        send_line();
    endtask

    task automatic argument_line(input int words);
        for (int i = 0; i < words; i++) begin
            push_word($urandom_range(1, 2));
            push_gap();
        end
        send_line();
    endtask

    task automatic redirect_flood_line();
        for (int i = 0; i < 33; i++) begin
            push_text("<");
            push_word(1);
        end
        send_line();
    endtask

    initial begin
        int random_start;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed lines
        send_request(8'hFF, 1'b1);
        push_text("x?|\"<\"2>o");
        send_line();
        push_text("<>");
        send_line();
        push_text("''\t'a");
        send_line();
        push_text(">>f 2");
        send_line();
        send_request(8'h00, 1'b0);
        send_request(8'hFF, 1'b0);
        send_request(8'hFF, 1'b1);
        drain_results();

        // limit lines
        pipeline_line(7);
        pipeline_line(8);
        argument_line(15);
        argument_line(16);
        redirect_flood_line();

        random_start = sent;
        while (sent < TOTAL_REQUESTS) begin
            steady = (sent - random_start >= 30) && (sent - random_start < 100);
            if ($urandom_range(0, 99) < 5) drain_results();
            random_line();
        end
        steady = 1'b0;

        drain_results();
        repeat (10) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
